### design/onp_pkg.sv
package onp_pkg;

  // Field widths
  localparam int unsigned COMP_W    = 16;
  localparam int unsigned CODE_W    = 16;
  localparam int unsigned FRAC_BITS = 18;

  // Derived widths
  localparam int unsigned MAG_W = COMP_W;          // |c| up to 2^(COMP_W-1)
  localparam int unsigned SUM_W = COMP_W + 1;      // |x|+|y|+|z| < 2^(COMP_W+1)
  localparam int unsigned REM_W = SUM_W + 1;       // shifted partial remainder
  localparam int unsigned Q_W   = FRAC_BITS + 1;   // quotient 0 .. 2^FRAC_BITS
  localparam int unsigned T_W   = FRAC_BITS + 2;   // mapped value 0 .. 2^(FRAC_BITS+1)
  localparam int unsigned P_W   = T_W + CODE_W;    // t * (2^CODE_W - 1)

  // Request queue
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Divider pipeline: one quotient bit per stage
  localparam int unsigned DIV_STAGES = Q_W;

  localparam logic [Q_W-1:0] ONE_Q = Q_W'(1) << FRAC_BITS;

  // Classified request, front to back
  typedef struct packed {
    logic [MAG_W-1:0] ax;
    logic [MAG_W-1:0] ay;
    logic [SUM_W-1:0] sum;
    logic             nx;
    logic             ny;
    logic             nz;
    logic             zero;
  } req_t;

  // One divider pipeline stage
  typedef struct packed {
    logic [SUM_W-1:0] rx;
    logic [SUM_W-1:0] ry;
    logic [Q_W-1:0]   qx;
    logic [Q_W-1:0]   qy;
    logic [SUM_W-1:0] sum;
    logic             nx;
    logic             ny;
    logic             nz;
    logic             zero;
  } div_stage_t;

  typedef struct packed {
    logic             bit_q;
    logic [SUM_W-1:0] rem;
  } div_step_t;

  // One restoring division step
  function automatic div_step_t div_step(input logic [REM_W-1:0] r,
                                         input logic [SUM_W-1:0] d);
    div_step_t res;
    logic [REM_W-1:0] dx;
    logic [REM_W-1:0] diff;
    dx   = {1'b0, d};
    diff = r - dx;
    res.bit_q = (r >= dx);
    res.rem   = res.bit_q ? diff[SUM_W-1:0] : r[SUM_W-1:0];
    return res;
  endfunction

endpackage

### design/onp_front.sv
module onp_front
  import onp_pkg::*;
(
  input  logic [COMP_W-1:0] normal_x_i,
  input  logic [COMP_W-1:0] normal_y_i,
  input  logic [COMP_W-1:0] normal_z_i,
  output req_t              req_o
);

  logic [MAG_W-1:0] az;

  // two's complement magnitude; the most negative value maps to 2^(COMP_W-1)
  function automatic logic [MAG_W-1:0] mag(input logic [COMP_W-1:0] c);
    logic [COMP_W-1:0] neg;
    neg = ~c + COMP_W'(1);
    return c[COMP_W-1] ? neg : c;
  endfunction

  // signs, magnitudes and the L1 norm
  always_comb begin
    req_o.nx   = normal_x_i[COMP_W-1];
    req_o.ny   = normal_y_i[COMP_W-1];
    req_o.nz   = normal_z_i[COMP_W-1];
    req_o.ax   = mag(normal_x_i);
    req_o.ay   = mag(normal_y_i);
    az         = mag(normal_z_i);
    req_o.sum  = SUM_W'(req_o.ax) + SUM_W'(req_o.ay) + SUM_W'(az);
    req_o.zero = (req_o.sum == '0);
  end

endmodule

### design/onp_fifo.sv
module onp_fifo
  import onp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  req_t data_i,
  input  logic pop_i,
  output req_t data_o,
  output logic empty_o,
  output logic full_o
);

  req_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CNT_W'(FIFO_DEPTH));
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### design/onp_div_pipe.sv
module onp_div_pipe
  import onp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  req_t       req_i,
  output logic       valid_o,
  output div_stage_t stage_o
);

  div_stage_t             st_q [DIV_STAGES];
  div_stage_t             st_d [DIV_STAGES];
  logic [DIV_STAGES-1:0]  vld_q;
  logic [DIV_STAGES-1:0]  vld_d;

  // first step: integer quotient bit, remainder starts at the magnitude
  always_comb begin
    div_step_t sx, sy;
    sx = div_step(REM_W'(req_i.ax), req_i.sum);
    sy = div_step(REM_W'(req_i.ay), req_i.sum);
    st_d[0].rx   = sx.rem;
    st_d[0].ry   = sy.rem;
    st_d[0].qx   = Q_W'(sx.bit_q);
    st_d[0].qy   = Q_W'(sy.bit_q);
    st_d[0].sum  = req_i.sum;
    st_d[0].nx   = req_i.nx;
    st_d[0].ny   = req_i.ny;
    st_d[0].nz   = req_i.nz;
    st_d[0].zero = req_i.zero;
    vld_d[0]     = valid_i;
  end

  // fraction bits, one per stage
  for (genvar k = 1; k < DIV_STAGES; k++) begin : g_stage
    always_comb begin
      div_step_t sx, sy;
      sx = div_step({st_q[k-1].rx, 1'b0}, st_q[k-1].sum);
      sy = div_step({st_q[k-1].ry, 1'b0}, st_q[k-1].sum);
      st_d[k]      = st_q[k-1];
      st_d[k].rx   = sx.rem;
      st_d[k].ry   = sy.rem;
      st_d[k].qx   = {st_q[k-1].qx[Q_W-2:0], sx.bit_q};
      st_d[k].qy   = {st_q[k-1].qy[Q_W-2:0], sy.bit_q};
      vld_d[k]     = vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DIV_STAGES; i++) begin
      st_q[i] <= st_d[i];
    end
  end

  assign valid_o = vld_q[DIV_STAGES-1];
  assign stage_o = st_q[DIV_STAGES-1];

endmodule

### design/onp_back.sv
module onp_back
  import onp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  req_t              req_i,
  output logic              done_o,
  output logic [CODE_W-1:0] code_u_o,
  output logic [CODE_W-1:0] code_v_o,
  output logic              zero_vector_o
);

  logic       div_vld;
  div_stage_t div_res;

  logic           map_vld_q;
  logic [T_W-1:0] tu_q, tu_d;
  logic [T_W-1:0] tv_q, tv_d;
  logic           zero_q;

  logic              out_vld_q;
  logic [CODE_W-1:0] code_u_q, code_u_d;
  logic [CODE_W-1:0] code_v_q, code_v_d;
  logic              zero_out_q;

  onp_div_pipe u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .req_i   (req_i),
    .valid_o (div_vld),
    .stage_o (div_res)
  );

  // hemisphere fold and map to [0, 2]
  always_comb begin
    logic [Q_W-1:0] mx, my;
    mx   = div_res.nz ? ONE_Q - div_res.qy : div_res.qx;
    my   = div_res.nz ? ONE_Q - div_res.qx : div_res.qy;
    tu_d = div_res.nx ? T_W'(ONE_Q) - T_W'(mx) : T_W'(ONE_Q) + T_W'(mx);
    tv_d = div_res.ny ? T_W'(ONE_Q) - T_W'(my) : T_W'(ONE_Q) + T_W'(my);
  end

  // code = t * (2^CODE_W - 1) >> (FRAC_BITS + 1)
  function automatic logic [CODE_W-1:0] scale(input logic [T_W-1:0] t);
    logic [P_W-1:0] p;
    p = (P_W'(t) << CODE_W) - P_W'(t);
    return p[FRAC_BITS+1 +: CODE_W];
  endfunction

  always_comb begin
    code_u_d = zero_q ? '0 : scale(tu_q);
    code_v_d = zero_q ? '0 : scale(tv_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      map_vld_q <= div_vld;
      out_vld_q <= map_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tu_q       <= tu_d;
    tv_q       <= tv_d;
    zero_q     <= div_res.zero;
    code_u_q   <= code_u_d;
    code_v_q   <= code_v_d;
    zero_out_q <= zero_q;
  end

  assign done_o        = out_vld_q;
  assign code_u_o      = code_u_q;
  assign code_v_o      = code_v_q;
  assign zero_vector_o = zero_out_q;

endmodule

### design/octahedral_normal_pack.sv
// Channel   Handshake          Ports
// request   start / busy       normal_x_i, normal_y_i, normal_z_i
// result    done_o (strobe)    code_u_o, code_v_o, zero_vector_o
//
// One request per cycle sustained.
// Results pass through the queue, the divider pipeline (one quotient bit per stage,
// 19 stages), the fold register and the scaling register.
// Reset (rst_ni, async, active low) empties the queue and clears all valid bits.
// The back end never stalls, so the queue drains every cycle and busy stays low.
module octahedral_normal_pack
  import onp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [COMP_W-1:0] normal_x_i,
  input  logic [COMP_W-1:0] normal_y_i,
  input  logic [COMP_W-1:0] normal_z_i,
  output logic              done_o,
  output logic [CODE_W-1:0] code_u_o,
  output logic [CODE_W-1:0] code_v_o,
  output logic              zero_vector_o
);

  localparam int unsigned LATENCY = DIV_STAGES + 3;

  req_t front_req;
  req_t queue_req;
  logic queue_empty;
  logic queue_full;
  logic accept;

  assign busy   = queue_full;
  assign accept = start && !busy;

  // classify
  onp_front u_front (
    .normal_x_i (normal_x_i),
    .normal_y_i (normal_y_i),
    .normal_z_i (normal_z_i),
    .req_o      (front_req)
  );

  // decoupling queue
  onp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (front_req),
    .pop_i   (!queue_empty),
    .data_o  (queue_req),
    .empty_o (queue_empty),
    .full_o  (queue_full)
  );

  // divide, fold, scale
  onp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (!queue_empty),
    .req_i         (queue_req),
    .done_o        (done_o),
    .code_u_o      (code_u_o),
    .code_v_o      (code_v_o),
    .zero_vector_o (zero_vector_o)
  );

`ifndef SYNTHESIS
  a_queue_never_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !queue_full) else $error("request queue filled up");

  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LATENCY done_o) else $error("result missing after request");

  a_zero_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && zero_vector_o) |-> (code_u_o == '0 && code_v_o == '0))
    else $error("zero vector with nonzero codes");
`endif

endmodule

### tb/octahedral_normal_pack_test.sv
`timescale 1ns / 100ps

module octahedral_normal_pack_test;
  import onp_pkg::*;

  localparam int unsigned RANDOM_REQUESTS = 1900;
  localparam int unsigned DRAIN_LIMIT     = 400;   // cycles allowed for the tail
  localparam int unsigned SETTLE_CYCLES   = 30;    // margin past the pipeline depth
  localparam bit [63:0]   UNIT_Q18        = 64'(1) << FRAC_BITS;

  typedef logic [COMP_W-1:0] comp_t;

  // One expected result
  typedef struct {
    logic [CODE_W-1:0] u;
    logic [CODE_W-1:0] v;
    logic              zero;
  } oct_code_t;

  // Predicts octahedral codes for accepted requests, checks results in order
  class oct_code_checker;
    oct_code_t   expected_codes[$];
    int unsigned errors;
    int unsigned noted;
    int unsigned checked;
    int unsigned folds;
    int unsigned zeros;

    // Magnitude of a two's complement component; -2^(W-1) maps to 2^(W-1)
    static function bit [63:0] comp_magnitude(comp_t c);
      return c[COMP_W-1] ? (64'(1) << COMP_W) - 64'(c) : 64'(c);
    endfunction

    // Map a signed Q18 magnitude to [0, 2^19] and scale to a code
    static function logic [CODE_W-1:0] scale_code(bit [63:0] mag, bit neg);
      bit [63:0] t;
      t = neg ? UNIT_Q18 - mag : UNIT_Q18 + mag;
      return CODE_W'((t * ((64'(1) << CODE_W) - 1)) >> (FRAC_BITS + 1));
    endfunction

    static function oct_code_t octa_encode(comp_t x, comp_t y, comp_t z);
      bit [63:0] ax, ay, az, s, qx, qy, mx, my;
      oct_code_t r;
      ax = comp_magnitude(x);
      ay = comp_magnitude(y);
      az = comp_magnitude(z);
      s  = ax + ay + az;
      if (s == 0) begin
        r.u    = '0;
        r.v    = '0;
        r.zero = 1'b1;
        return r;
      end
      qx = (ax << FRAC_BITS) / s;
      qy = (ay << FRAC_BITS) / s;
      // lower hemisphere folds outward, each coordinate keeps its own sign
      if (z[COMP_W-1]) begin
        mx = UNIT_Q18 - qy;
        my = UNIT_Q18 - qx;
      end else begin
        mx = qx;
        my = qy;
      end
      r.u    = scale_code(mx, x[COMP_W-1]);
      r.v    = scale_code(my, y[COMP_W-1]);
      r.zero = 1'b0;
      return r;
    endfunction

    function void note_request(comp_t x, comp_t y, comp_t z);
      oct_code_t e;
      e = octa_encode(x, y, z);
      noted++;
      if (e.zero) zeros++;
      else if (z[COMP_W-1]) folds++;
      expected_codes.push_back(e);
    endfunction

    function void check_result(logic [CODE_W-1:0] u, logic [CODE_W-1:0] v, logic zf);
      oct_code_t e;
      if (expected_codes.size() == 0) begin
        $display("%0t: result with no request pending: u=%h v=%h zero=%b",
                 $time, u, v, zf);
        errors++;
        return;
      end
      e = expected_codes.pop_front();
      checked++;
      if (u !== e.u) begin
        $display("%0t: code_u mismatch: expected %h, got %h", $time, e.u, u);
        errors++;
      end
      if (v !== e.v) begin
        $display("%0t: code_v mismatch: expected %h, got %h", $time, e.v, v);
        errors++;
      end
      if (zf !== e.zero) begin
        $display("%0t: zero_vector mismatch: expected %b, got %b", $time, e.zero, zf);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [COMP_W-1:0] normal_x_i;
  logic [COMP_W-1:0] normal_y_i;
  logic [COMP_W-1:0] normal_z_i;
  logic              done_o;
  logic [CODE_W-1:0] code_u_o;
  logic [CODE_W-1:0] code_v_o;
  logic              zero_vector_o;

  oct_code_checker board;
  bit              burst_mode;

  octahedral_normal_pack dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .normal_x_i    (normal_x_i),
    .normal_y_i    (normal_y_i),
    .normal_z_i    (normal_z_i),
    .done_o        (done_o),
    .code_u_o      (code_u_o),
    .code_v_o      (code_v_o),
    .zero_vector_o (zero_vector_o)
  );

  always #5 clk_i = ~clk_i;

  // Watch both sides: note accepted requests, check strobed results
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) begin
      board.note_request(normal_x_i, normal_y_i, normal_z_i);
    end
    if (rst_ni && done_o) begin
      board.check_result(code_u_o, code_v_o, zero_vector_o);
    end
  end

  // Hold a request until the block takes it
  task automatic send_normal(comp_t x, comp_t y, comp_t z);
    start      <= 1'b1;
    normal_x_i <= x;
    normal_y_i <= y;
    normal_z_i <= z;
    do begin
      @(posedge clk_i);
    end while (busy);
  endtask

  // Idle with start low and garbage on the data ports
  task automatic idle_for(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      start      <= 1'b0;
      normal_x_i <= comp_t'($urandom);
      normal_y_i <= comp_t'($urandom);
      normal_z_i <= comp_t'($urandom);
      @(posedge clk_i);
    end
  endtask

  // Mostly short gaps, a few long ones; none at all in burst stretches
  function automatic int unsigned gap_len();
    int unsigned r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Component mix: zeros, extremes, tiny values, full range
  function automatic comp_t rand_comp();
    case ($urandom_range(0, 9))
      0:       return '0;
      1: begin
        case ($urandom_range(0, 3))
          0:       return comp_t'(16'h8000);
          1:       return comp_t'(16'h7FFF);
          2:       return comp_t'(16'hFFFF);
          default: return comp_t'(16'h0001);
        endcase
      end
      2, 3:    return comp_t'(int'($urandom_range(0, 8)) - 4);
      default: return comp_t'($urandom);
    endcase
  endfunction

  // Directed vectors: axes, extremes, zero, folds with tiny or zero components
  localparam int NUM_DIRECTED = 24;
  localparam logic [15:0] DIR_X [NUM_DIRECTED] = '{
    16'h0000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000,
    16'h7FFF, 16'h0001, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h0000, 16'hFFFF,
    16'h49E7, 16'h5A82, 16'h0000, 16'h8000, 16'h3039, 16'hFFFF, 16'h0000, 16'h8000};
  localparam logic [15:0] DIR_Y [NUM_DIRECTED] = '{
    16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h8000,
    16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'hFFFF, 16'h0005, 16'hFFFF,
    16'h49E7, 16'h0000, 16'hA57E, 16'h7FFF, 16'hE57B, 16'hFFFF, 16'h0000, 16'h0000};
  localparam logic [15:0] DIR_Z [NUM_DIRECTED] = '{
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 16'h8000,
    16'h7FFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF,
    16'h49E7, 16'hA57E, 16'hA57E, 16'hFFFF, 16'h8AD0, 16'h7FFF, 16'h0001, 16'h0000};

  initial begin
    int unsigned drain;
    board        = new();
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    normal_x_i   = '0;
    normal_y_i   = '0;
    normal_z_i   = '0;
    burst_mode   = 1'b0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, back to back
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_normal(DIR_X[i], DIR_Y[i], DIR_Z[i]);
    end
    idle_for(3);

    // random part, with burst stretches and occasional zero vectors
    for (int unsigned n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 100 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 39) == 0) begin
        send_normal('0, '0, '0);
      end else begin
        send_normal(rand_comp(), rand_comp(), rand_comp());
      end
      idle_for(gap_len());
    end
    idle_for(1);

    // drain the pipeline, then allow for any stray strobes
    drain = 0;
    while (board.expected_codes.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.expected_codes.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, board.expected_codes.size());
      board.errors += board.expected_codes.size();
    end

    $display("Sent %0d normals (%0d folded, %0d zero vectors); checked %0d results.",
             board.noted, board.folds, board.zeros, board.checked);
    $display("Errors: %0d", board.errors);
    if (board.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("%0t: run timed out", $time);
    $display("Verification failed");
    $finish;
  end

endmodule
